// ===== rtl/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared constants, codes and controller/datapath types for the
// nearest segment classifier.
// ----------------------------------------------------------------------------
package nsc_pkg;

    // Table size and coordinate format
    localparam int NUM_SEGMENTS = 9;
    localparam int COORD_BITS   = 16;
    localparam int IDX_BITS     = 4;
    localparam int SEG_CNT_BITS = $clog2(NUM_SEGMENTS);

    // Arithmetic widths
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int MUL_BITS     = DIFF_BITS + 1;
    localparam int PROD_BITS    = 2 * MUL_BITS;
    localparam int DIST_BITS    = 34;
    localparam int DOT_BITS     = DIST_BITS + 1;
    localparam int HALF_BITS    = DIST_BITS / 2;
    localparam int NUM_BITS     = 2 * DIST_BITS;
    localparam int DIV_STEPS    = DIST_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
    localparam int ENTRY_BITS   = 6 * COORD_BITS;
    localparam int MUL_SEL_BITS = 4;

    // Input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    // Multiplier operand selection, in issue order
    typedef enum logic [MUL_SEL_BITS-1:0] {
        MUL_AC_X, MUL_AC_Y, MUL_AC_Z,
        MUL_BC_X, MUL_BC_Y, MUL_BC_Z,
        MUL_LEN_X, MUL_LEN_Y, MUL_LEN_Z,
        MUL_DOT_X, MUL_DOT_Y, MUL_DOT_Z,
        MUL_HH, MUL_HL, MUL_LL
    } mul_sel_t;

    // Where the projection falls on the segment
    typedef enum logic [1:0] {
        DIST_START,
        DIST_END,
        DIST_PERP
    } dist_case_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                    seg_write;
        logic                    point_load;
        logic                    diff_load;
        logic                    acc_clr;
        logic                    mul_en;
        mul_sel_t                mul_sel;
        logic                    num_clr;
        logic                    div_load;
        logic                    div_step;
        logic                    dist_simple;
        logic                    dist_perp;
        logic                    best_update;
        logic                    rsp_load;
        logic [SEG_CNT_BITS-1:0] seg;
    } nsc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        dist_case_t dist_case;
    } nsc_status_t;

endpackage

// ===== rtl/nsc_req_if.sv =====
// ----------------------------------------------------------------------------
// nsc_req_if
// Request channel: segment writes and point queries.
// ----------------------------------------------------------------------------
interface nsc_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   cmd;
    logic [nsc_pkg::IDX_BITS-1:0]           seg_index;
    logic signed [nsc_pkg::COORD_BITS-1:0]  point_x;
    logic signed [nsc_pkg::COORD_BITS-1:0]  point_y;
    logic signed [nsc_pkg::COORD_BITS-1:0]  point_z;
    logic signed [nsc_pkg::COORD_BITS-1:0]  end_x;
    logic signed [nsc_pkg::COORD_BITS-1:0]  end_y;
    logic signed [nsc_pkg::COORD_BITS-1:0]  end_z;

    modport source (
        output valid, cmd, seg_index, point_x, point_y, point_z, end_x, end_y, end_z,
        input  ready
    );

    modport sink (
        input  valid, cmd, seg_index, point_x, point_y, point_z, end_x, end_y, end_z,
        output ready
    );
endinterface

// ===== rtl/nsc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nsc_rsp_if
// Response channel: nearest two segments and their squared distances.
// ----------------------------------------------------------------------------
interface nsc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [nsc_pkg::IDX_BITS-1:0]    nearest_segment;
    logic [nsc_pkg::IDX_BITS-1:0]    second_segment;
    logic [nsc_pkg::DIST_BITS-1:0]   nearest_dist_sq;
    logic [nsc_pkg::DIST_BITS-1:0]   second_dist_sq;

    modport source (
        output valid, nearest_segment, second_segment, nearest_dist_sq, second_dist_sq,
        input  ready
    );

    modport sink (
        input  valid, nearest_segment, second_segment, nearest_dist_sq, second_dist_sq,
        output ready
    );
endinterface

// ===== rtl/nearest_segment_classifier.sv =====
// ----------------------------------------------------------------------------
// nearest_segment_classifier
// Segment write: accepted while idle, no result. Point: one transaction at
// a time; each of the 9 segments goes either the short path (projection
// before start, past end, or zero length) or the perpendicular path, which
// adds squaring on the shared multiplier and the bit-serial divider. Async
// active-low reset clears control; the segment table holds nothing until
// written.
// ----------------------------------------------------------------------------
module nearest_segment_classifier (
    input  logic        clk,
    input  logic        rst_n,
    nsc_req_if.sink     req,
    nsc_rsp_if.source   rsp
);

    nsc_pkg::nsc_cmd_t    cmd;
    nsc_pkg::nsc_status_t status;

    // Sequencer
    nsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and storage
    nsc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .seg_index       (req.seg_index),
        .point_x         (req.point_x),
        .point_y         (req.point_y),
        .point_z         (req.point_z),
        .end_x           (req.end_x),
        .end_y           (req.end_y),
        .end_z           (req.end_z),
        .nearest_segment (rsp.nearest_segment),
        .second_segment  (rsp.second_segment),
        .nearest_dist_sq (rsp.nearest_dist_sq),
        .second_dist_sq  (rsp.second_dist_sq)
    );

endmodule

// ===== rtl/nsc_ram.sv =====
// ----------------------------------------------------------------------------
// nsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/nsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// nsc_ctrl
// Sequencer: walks the segment table for each point, steps the shared
// multiplier, the divider and the running two-minimum search.
// ----------------------------------------------------------------------------
module nsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_cmd,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  nsc_pkg::nsc_status_t status,
    output nsc_pkg::nsc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DIFF,
        ST_MUL,
        ST_MUL_DRAIN,
        ST_DECIDE,
        ST_SQ,
        ST_SQ_DRAIN,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    state_t                               state_reg, state_next;
    logic [nsc_pkg::SEG_CNT_BITS-1:0]     seg_reg, seg_next;
    nsc_pkg::mul_sel_t                    step_reg, step_next;
    logic [nsc_pkg::DIV_CNT_BITS-1:0]     div_cnt_reg, div_cnt_next;
    logic                                 rsp_valid_reg, rsp_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        step_next    = step_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.seg      = seg_reg;
        cmd.mul_sel  = step_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_cmd == nsc_pkg::CMD_WRITE)
                    begin
                        cmd.seg_write = 1'b1;
                    end
                    else
                    begin
                        cmd.point_load = 1'b1;
                        seg_next       = '0;
                        state_next     = ST_ADDR;
                    end
                end
            end
            ST_ADDR:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff_load = 1'b1;
                cmd.acc_clr   = 1'b1;
                step_next     = nsc_pkg::MUL_AC_X;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == nsc_pkg::MUL_DOT_Z)
                begin
                    state_next = ST_MUL_DRAIN;
                end
                else
                begin
                    step_next = nsc_pkg::mul_sel_t'(
                        nsc_pkg::MUL_SEL_BITS'(step_reg) + nsc_pkg::MUL_SEL_BITS'(1));
                end
            end
            ST_MUL_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.num_clr = 1'b1;
                if (status.dist_case == nsc_pkg::DIST_PERP)
                begin
                    step_next  = nsc_pkg::MUL_HH;
                    state_next = ST_SQ;
                end
                else
                begin
                    cmd.dist_simple = 1'b1;
                    state_next      = ST_UPDATE;
                end
            end
            ST_SQ:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == nsc_pkg::MUL_LL)
                begin
                    state_next = ST_SQ_DRAIN;
                end
                else
                begin
                    step_next = nsc_pkg::mul_sel_t'(
                        nsc_pkg::MUL_SEL_BITS'(step_reg) + nsc_pkg::MUL_SEL_BITS'(1));
                end
            end
            ST_SQ_DRAIN:
            begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_load = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == nsc_pkg::DIV_CNT_BITS'(nsc_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + nsc_pkg::DIV_CNT_BITS'(1);
                end
            end
            ST_FIN:
            begin
                cmd.dist_perp = 1'b1;
                state_next    = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.best_update = 1'b1;
                if (seg_reg == nsc_pkg::SEG_CNT_BITS'(nsc_pkg::NUM_SEGMENTS - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    seg_next   = seg_reg + nsc_pkg::SEG_CNT_BITS'(1);
                    state_next = ST_ADDR;
                end
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hold the result until taken, then drop valid
        if (cmd.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_reg       <= '0;
            step_reg      <= nsc_pkg::MUL_AC_X;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            step_reg      <= step_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== rtl/nsc_dp.sv =====
// ----------------------------------------------------------------------------
// nsc_dp
// Datapath: segment table, coordinate differences, shared 18x18 multiplier
// with accumulators, restoring divider, two-minimum tracker, result register.
// ----------------------------------------------------------------------------
module nsc_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  nsc_pkg::nsc_cmd_t                      cmd,
    output nsc_pkg::nsc_status_t                   status,
    input  logic [nsc_pkg::IDX_BITS-1:0]           seg_index,
    input  logic signed [nsc_pkg::COORD_BITS-1:0]  point_x,
    input  logic signed [nsc_pkg::COORD_BITS-1:0]  point_y,
    input  logic signed [nsc_pkg::COORD_BITS-1:0]  point_z,
    input  logic signed [nsc_pkg::COORD_BITS-1:0]  end_x,
    input  logic signed [nsc_pkg::COORD_BITS-1:0]  end_y,
    input  logic signed [nsc_pkg::COORD_BITS-1:0]  end_z,
    output logic [nsc_pkg::IDX_BITS-1:0]           nearest_segment,
    output logic [nsc_pkg::IDX_BITS-1:0]           second_segment,
    output logic [nsc_pkg::DIST_BITS-1:0]          nearest_dist_sq,
    output logic [nsc_pkg::DIST_BITS-1:0]          second_dist_sq
);

    localparam int CB = nsc_pkg::COORD_BITS;
    localparam int DB = nsc_pkg::DIST_BITS;

    logic                                  ram_we;
    logic [nsc_pkg::ENTRY_BITS-1:0]        ram_rdata;
    logic signed [CB-1:0]                  point_reg [3];
    logic signed [CB-1:0]                  seg_s [3];
    logic signed [CB-1:0]                  seg_e [3];
    logic signed [nsc_pkg::DIFF_BITS-1:0]  ac_reg [3];
    logic signed [nsc_pkg::DIFF_BITS-1:0]  bc_reg [3];
    logic signed [nsc_pkg::DIFF_BITS-1:0]  b_reg [3];
    logic signed [nsc_pkg::MUL_BITS-1:0]   opa, opb;
    logic signed [nsc_pkg::PROD_BITS-1:0]  prod;
    logic signed [nsc_pkg::PROD_BITS-1:0]  prod_reg;
    nsc_pkg::mul_sel_t                     prod_sel_reg;
    logic                                  prod_vld_reg;
    logic [DB-1:0]                         ac2_reg, bc2_reg, len2_reg;
    logic signed [nsc_pkg::DOT_BITS-1:0]   dot_reg;
    logic [nsc_pkg::NUM_BITS-1:0]          num_reg;
    logic [DB-1:0]                         rem_reg, numlo_reg, quo_reg;
    logic [DB:0]                           trial;
    logic [DB:0]                           trial_diff;
    logic [DB-1:0]                         dist_reg;
    logic [DB-1:0]                         d1_reg, d2_reg;
    logic [nsc_pkg::SEG_CNT_BITS-1:0]      n1_reg, n2_reg;
    logic [nsc_pkg::IDX_BITS-1:0]          rsp_n1_reg, rsp_n2_reg;
    logic [DB-1:0]                         rsp_d1_reg, rsp_d2_reg;

    // Segment table: start in the low half, end in the high half
    assign ram_we = cmd.seg_write && (int'(seg_index) < nsc_pkg::NUM_SEGMENTS);

    nsc_ram #(
        .WIDTH (nsc_pkg::ENTRY_BITS),
        .DEPTH (nsc_pkg::NUM_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nsc_pkg::SEG_CNT_BITS'(seg_index)),
        .wdata ({end_z, end_y, end_x, point_z, point_y, point_x}),
        .raddr (cmd.seg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            seg_s[k] = ram_rdata[k*CB +: CB];
            seg_e[k] = ram_rdata[(k+3)*CB +: CB];
        end
    end

    // Capture the query point and form the per-segment differences
    always_ff @(posedge clk)
    begin
        if (cmd.point_load)
        begin
            point_reg[0] <= point_x;
            point_reg[1] <= point_y;
            point_reg[2] <= point_z;
        end
        if (cmd.diff_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ac_reg[k] <= nsc_pkg::DIFF_BITS'(point_reg[k]) - nsc_pkg::DIFF_BITS'(seg_s[k]);
                bc_reg[k] <= nsc_pkg::DIFF_BITS'(point_reg[k]) - nsc_pkg::DIFF_BITS'(seg_e[k]);
                b_reg[k]  <= nsc_pkg::DIFF_BITS'(seg_e[k]) - nsc_pkg::DIFF_BITS'(seg_s[k]);
            end
        end
    end

    // Select multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            nsc_pkg::MUL_AC_X:  begin opa = nsc_pkg::MUL_BITS'(ac_reg[0]); opb = opa; end
            nsc_pkg::MUL_AC_Y:  begin opa = nsc_pkg::MUL_BITS'(ac_reg[1]); opb = opa; end
            nsc_pkg::MUL_AC_Z:  begin opa = nsc_pkg::MUL_BITS'(ac_reg[2]); opb = opa; end
            nsc_pkg::MUL_BC_X:  begin opa = nsc_pkg::MUL_BITS'(bc_reg[0]); opb = opa; end
            nsc_pkg::MUL_BC_Y:  begin opa = nsc_pkg::MUL_BITS'(bc_reg[1]); opb = opa; end
            nsc_pkg::MUL_BC_Z:  begin opa = nsc_pkg::MUL_BITS'(bc_reg[2]); opb = opa; end
            nsc_pkg::MUL_LEN_X: begin opa = nsc_pkg::MUL_BITS'(b_reg[0]); opb = opa; end
            nsc_pkg::MUL_LEN_Y: begin opa = nsc_pkg::MUL_BITS'(b_reg[1]); opb = opa; end
            nsc_pkg::MUL_LEN_Z: begin opa = nsc_pkg::MUL_BITS'(b_reg[2]); opb = opa; end
            nsc_pkg::MUL_DOT_X:
            begin
                opa = nsc_pkg::MUL_BITS'(b_reg[0]);
                opb = nsc_pkg::MUL_BITS'(ac_reg[0]);
            end
            nsc_pkg::MUL_DOT_Y:
            begin
                opa = nsc_pkg::MUL_BITS'(b_reg[1]);
                opb = nsc_pkg::MUL_BITS'(ac_reg[1]);
            end
            nsc_pkg::MUL_DOT_Z:
            begin
                opa = nsc_pkg::MUL_BITS'(b_reg[2]);
                opb = nsc_pkg::MUL_BITS'(ac_reg[2]);
            end
            nsc_pkg::MUL_HH:
            begin
                opa = $signed(nsc_pkg::MUL_BITS'(dot_reg[DB-1:nsc_pkg::HALF_BITS]));
                opb = opa;
            end
            nsc_pkg::MUL_HL:
            begin
                opa = $signed(nsc_pkg::MUL_BITS'(dot_reg[DB-1:nsc_pkg::HALF_BITS]));
                opb = $signed(nsc_pkg::MUL_BITS'(dot_reg[nsc_pkg::HALF_BITS-1:0]));
            end
            nsc_pkg::MUL_LL:
            begin
                opa = $signed(nsc_pkg::MUL_BITS'(dot_reg[nsc_pkg::HALF_BITS-1:0]));
                opb = opa;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod = opa * opb;

    // Register the product with its destination tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod;
        prod_sel_reg <= cmd.mul_sel;
    end

    // Accumulate products into sums of squares, dot product and dot squared
    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            ac2_reg  <= '0;
            bc2_reg  <= '0;
            len2_reg <= '0;
            dot_reg  <= '0;
        end
        if (cmd.num_clr)
        begin
            num_reg <= '0;
        end
        if (prod_vld_reg)
        begin
            case (prod_sel_reg)
                nsc_pkg::MUL_AC_X, nsc_pkg::MUL_AC_Y, nsc_pkg::MUL_AC_Z:
                    ac2_reg <= ac2_reg + prod_reg[DB-1:0];
                nsc_pkg::MUL_BC_X, nsc_pkg::MUL_BC_Y, nsc_pkg::MUL_BC_Z:
                    bc2_reg <= bc2_reg + prod_reg[DB-1:0];
                nsc_pkg::MUL_LEN_X, nsc_pkg::MUL_LEN_Y, nsc_pkg::MUL_LEN_Z:
                    len2_reg <= len2_reg + prod_reg[DB-1:0];
                nsc_pkg::MUL_DOT_X, nsc_pkg::MUL_DOT_Y, nsc_pkg::MUL_DOT_Z:
                    dot_reg <= dot_reg + $signed(prod_reg[nsc_pkg::DOT_BITS-1:0]);
                nsc_pkg::MUL_HH:
                    num_reg <= num_reg + {prod_reg[DB-1:0], {DB{1'b0}}};
                nsc_pkg::MUL_HL:
                    num_reg <= num_reg
                             + (nsc_pkg::NUM_BITS'(prod_reg[DB-1:0]) << (nsc_pkg::HALF_BITS + 1));
                nsc_pkg::MUL_LL:
                    num_reg <= num_reg + nsc_pkg::NUM_BITS'(prod_reg[DB-1:0]);
                default:
                    num_reg <= num_reg;
            endcase
        end
    end

    // Classify the projection against the segment ends
    always_comb
    begin
        if ((len2_reg == '0) || dot_reg[nsc_pkg::DOT_BITS-1])
        begin
            status.dist_case = nsc_pkg::DIST_START;
        end
        else if ($unsigned(dot_reg) > {1'b0, len2_reg})
        begin
            status.dist_case = nsc_pkg::DIST_END;
        end
        else
        begin
            status.dist_case = nsc_pkg::DIST_PERP;
        end
    end

    // Restoring divide of dot squared by the squared length, one bit per cycle
    assign trial      = {rem_reg, numlo_reg[DB-1]};
    assign trial_diff = trial - {1'b0, len2_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg   <= num_reg[nsc_pkg::NUM_BITS-1:DB];
            numlo_reg <= num_reg[DB-1:0];
            quo_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            numlo_reg <= {numlo_reg[DB-2:0], 1'b0};
            if (trial >= {1'b0, len2_reg})
            begin
                rem_reg <= trial_diff[DB-1:0];
                quo_reg <= {quo_reg[DB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DB-1:0];
                quo_reg <= {quo_reg[DB-2:0], 1'b0};
            end
        end
    end

    // Squared distance of the current segment
    always_ff @(posedge clk)
    begin
        if (cmd.dist_simple)
        begin
            dist_reg <= (status.dist_case == nsc_pkg::DIST_END) ? bc2_reg : ac2_reg;
        end
        else if (cmd.dist_perp)
        begin
            // subtract the quotient rounded up
            dist_reg <= ac2_reg - quo_reg - DB'(rem_reg != '0);
        end
    end

    // Track nearest and second nearest, first index wins ties
    always_ff @(posedge clk)
    begin
        if (cmd.best_update)
        begin
            if (cmd.seg == '0)
            begin
                d1_reg <= dist_reg;
                n1_reg <= cmd.seg;
            end
            else if (dist_reg < d1_reg)
            begin
                d2_reg <= d1_reg;
                n2_reg <= n1_reg;
                d1_reg <= dist_reg;
                n1_reg <= cmd.seg;
            end
            else if ((cmd.seg == nsc_pkg::SEG_CNT_BITS'(1)) || (dist_reg < d2_reg))
            begin
                d2_reg <= dist_reg;
                n2_reg <= cmd.seg;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_n1_reg <= nsc_pkg::IDX_BITS'(n1_reg);
            rsp_n2_reg <= nsc_pkg::IDX_BITS'(n2_reg);
            rsp_d1_reg <= d1_reg;
            rsp_d2_reg <= d2_reg;
        end
    end

    assign nearest_segment = rsp_n1_reg;
    assign second_segment  = rsp_n2_reg;
    assign nearest_dist_sq = rsp_d1_reg;
    assign second_dist_sq  = rsp_d2_reg;

endmodule
